@@ rtl/iwhc_pkg.sv @@
// ----------------------------------------------------------------------------
// iwhc_pkg
// Shared types and constants for the interrupt / wait-state / halt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package iwhc_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RAISE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [1:0] REGION_WS0  = 2'd0;
  localparam logic [1:0] REGION_WS1  = 2'd1;
  localparam logic [1:0] REGION_WS2  = 2'd2;
  localparam logic [1:0] REGION_SRAM = 2'd3;

  // I/O offsets
  localparam logic [9:0] CTL_BASE = 10'h200;
  localparam logic [9:0] CTL_LAST = 10'h20B;
  localparam logic [9:0] SYS_BASE = 10'h300;
  localparam logic [9:0] SYS_HALT = 10'h301;
  localparam logic [9:0] SYS_LAST = 10'h303;

  // byte index within the control group
  localparam logic [3:0] BYTE_IE_LO  = 4'd0;
  localparam logic [3:0] BYTE_IE_HI  = 4'd1;
  localparam logic [3:0] BYTE_IF_LO  = 4'd2;
  localparam logic [3:0] BYTE_IF_HI  = 4'd3;
  localparam logic [3:0] BYTE_WC_LO  = 4'd4;
  localparam logic [3:0] BYTE_WC_HI  = 4'd5;
  localparam logic [3:0] BYTE_PAD0   = 4'd6;
  localparam logic [3:0] BYTE_PAD1   = 4'd7;
  localparam logic [3:0] BYTE_IME_LO = 4'd8;
  localparam logic [3:0] BYTE_IME_HI = 4'd9;
  localparam logic [3:0] BYTE_PAD2   = 4'd10;
  localparam logic [3:0] BYTE_PAD3   = 4'd11;

  localparam int NUM_IRQ_SOURCES = 14;
  localparam logic [15:0] IRQ_SRC_MASK = 16'((32'd1 << NUM_IRQ_SOURCES) - 32'd1);

  localparam logic [3:0] NONSEQ_CYCLES [4] = '{4'd4, 4'd3, 4'd2, 4'd8};

  typedef struct packed {
    cmd_e        cmd;
    logic [9:0]  io_offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [13:0] irq_sources;
    logic [1:0]  wait_region;
    logic        sequential;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        open_bus;
    logic        irq_pending;
    logic        halted;
    logic [4:0]  wait_cycles;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/irq_waitstate_halt_control_top.sv @@
// ----------------------------------------------------------------------------
// irq_waitstate_halt_control_top
// Interrupt enable/flag, wait-state and halt control behind a stream port.
// ----------------------------------------------------------------------------
// One request enters per clock while the downstream side takes results. Each
// request sits in the input register, is decoded against the register file in
// a single pass, and its result lands in the output register at the next free
// edge, where m_tvalid rises and the result is held until it is taken; the
// sustained throughput is one request per cycle as long as the downstream
// side takes results. Register state is updated at the moment a request moves
// into the output register, so requests see the effect of all earlier ones in
// order. Reset clears the register file and both valid flags; no warm-up is
// needed.
`default_nettype none

module irq_waitstate_halt_control_top (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [9:0] io_offset, [11:10] access_size, [43:12] write_data,
  // [57:44] irq_sources, [59:58] wait_region, [60] sequential, [63:61] zero
  input  wire logic [63:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,

  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] read_data, [32] open_bus, [33] irq_pending, [34] halted,
  // [39:35] wait_cycles
  output logic      [39:0] m_tdata
);

  iwhc_pkg::item_t   in_item;
  logic              in_valid;
  iwhc_pkg::result_t result;
  iwhc_pkg::result_t out_result;
  logic              out_free;
  logic              advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd         <= iwhc_pkg::cmd_e'(s_tuser);
      in_item.io_offset   <= s_tdata[9:0];
      in_item.access_size <= s_tdata[11:10];
      in_item.write_data  <= s_tdata[43:12];
      in_item.irq_sources <= s_tdata[57:44];
      in_item.wait_region <= s_tdata[59:58];
      in_item.sequential  <= s_tdata[60];
    end
  end

  iwhc_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {out_result.wait_cycles, out_result.halted, out_result.irq_pending,
                    out_result.open_bus, out_result.read_data};

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are full");

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result appeared without a held request");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (!in_valid && m_tready) |=> !m_tvalid)
    else $error("result invented with no request in flight");

endmodule

`default_nettype wire

@@ rtl/iwhc_wait.sv @@
// ----------------------------------------------------------------------------
// iwhc_wait
// Wait-state cycle lookup from the wait control word.
// ----------------------------------------------------------------------------
`default_nettype none

module iwhc_wait (
  input  wire logic [14:0] wait_control,
  input  wire logic [1:0]  wait_region,
  input  wire logic        sequential,
  input  wire logic        word,
  output logic      [4:0]  wait_cycles
);

  logic [1:0] first;
  logic       second;
  logic [3:0] seq_cost;
  logic [3:0] lead_cost;

  always_comb begin
    first  = wait_control[3:2];
    second = wait_control[4];
    case (wait_region)
      iwhc_pkg::REGION_WS0: begin
        first  = wait_control[3:2];
        second = wait_control[4];
      end
      iwhc_pkg::REGION_WS1: begin
        first  = wait_control[6:5];
        second = wait_control[7];
      end
      default: begin
        first  = wait_control[9:8];
        second = wait_control[10];
      end
    endcase

    case (wait_region)
      iwhc_pkg::REGION_WS0: seq_cost = second ? 4'd1 : 4'd2;
      iwhc_pkg::REGION_WS1: seq_cost = second ? 4'd1 : 4'd4;
      default:              seq_cost = second ? 4'd1 : 4'd8;
    endcase

    lead_cost = sequential ? seq_cost : iwhc_pkg::NONSEQ_CYCLES[first];

    if (wait_region == iwhc_pkg::REGION_SRAM) begin
      // sram: flat cost regardless of length or kind
      wait_cycles = 5'(iwhc_pkg::NONSEQ_CYCLES[wait_control[1:0]]);
    end else begin
      wait_cycles = 5'(lead_cost) + (word ? 5'(seq_cost) : 5'd0);
    end
  end

endmodule

`default_nettype wire

@@ rtl/iwhc_regs.sv @@
// ----------------------------------------------------------------------------
// iwhc_regs
// Register file, address decode and interrupt / halt update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module iwhc_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire iwhc_pkg::item_t   item,
  output iwhc_pkg::result_t      result
);

  logic [15:0] irq_enable,    irq_enable_next;
  logic [15:0] irq_flags,     irq_flags_next;
  logic [14:0] wait_control,  wait_control_next;
  logic [15:0] master_enable, master_enable_next;
  logic [7:0]  post_boot_flag, post_boot_flag_next;
  logic        halt_state,    halt_state_next;
  logic        irq_line,      irq_line_next;

  logic [7:0]  view [16];
  logic [3:0]  off;
  logic [3:0]  idx;
  logic [7:0]  lane_byte;
  logic [2:0]  nbytes;
  logic [2:0]  lanes;
  logic [15:0] ack;
  logic        ctl_hit;
  logic        sys_hit;
  logic        pad_hit;
  logic        do_check;
  logic        halt_bit;
  logic [4:0]  wait_cycles;

  iwhc_wait u_wait (
    .wait_control (wait_control),
    .wait_region  (item.wait_region),
    .sequential   (item.sequential),
    .word         (item.access_size[1]),
    .wait_cycles  (wait_cycles)
  );

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      view[i] = 8'h00;
    end
    view[iwhc_pkg::BYTE_IE_LO]  = irq_enable[7:0];
    view[iwhc_pkg::BYTE_IE_HI]  = irq_enable[15:8];
    view[iwhc_pkg::BYTE_IF_LO]  = irq_flags[7:0];
    view[iwhc_pkg::BYTE_IF_HI]  = irq_flags[15:8];
    view[iwhc_pkg::BYTE_WC_LO]  = wait_control[7:0];
    view[iwhc_pkg::BYTE_WC_HI]  = {1'b0, wait_control[14:8]};
    view[iwhc_pkg::BYTE_IME_LO] = master_enable[7:0];
    view[iwhc_pkg::BYTE_IME_HI] = master_enable[15:8];
  end

  always_comb begin
    irq_enable_next     = irq_enable;
    irq_flags_next      = irq_flags;
    wait_control_next   = wait_control;
    master_enable_next  = master_enable;
    post_boot_flag_next = post_boot_flag;
    halt_state_next     = halt_state;
    irq_line_next       = irq_line;
    result              = '0;
    ack                 = 16'h0000;
    do_check            = 1'b0;
    halt_bit            = 1'b0;
    lanes               = 3'd0;
    idx                 = 4'd0;
    lane_byte           = 8'h00;

    off     = item.io_offset[3:0];
    ctl_hit = (item.io_offset >= iwhc_pkg::CTL_BASE) && (item.io_offset <= iwhc_pkg::CTL_LAST);
    sys_hit = (item.io_offset >= iwhc_pkg::SYS_BASE) && (item.io_offset <= iwhc_pkg::SYS_LAST);
    pad_hit = (off == iwhc_pkg::BYTE_PAD0) || (off == iwhc_pkg::BYTE_PAD1) ||
              (off == iwhc_pkg::BYTE_PAD2) || (off == iwhc_pkg::BYTE_PAD3);

    case (item.access_size)
      iwhc_pkg::SIZE_BYTE: nbytes = 3'd1;
      iwhc_pkg::SIZE_HALF: nbytes = 3'd2;
      default:             nbytes = 3'd4;
    endcase

    case (item.cmd)
      iwhc_pkg::CMD_READ: begin
        if (ctl_hit) begin
          if (!pad_hit) begin
            for (int k = 0; k < 4; k++) begin
              if (3'(k) < nbytes) begin
                result.read_data[8*k +: 8] = view[off + 4'(k)];
              end
            end
          end
        end else if (sys_hit) begin
          if (item.io_offset == iwhc_pkg::SYS_BASE && item.access_size == iwhc_pkg::SIZE_BYTE)
          begin
            result.read_data = {24'h0, post_boot_flag};
          end
        end else begin
          result.open_bus = 1'b1;
        end
      end

      iwhc_pkg::CMD_WRITE: begin
        if (ctl_hit) begin
          do_check = 1'b1;
          if (off < iwhc_pkg::BYTE_IF_LO) begin
            // word write to IE: low half lands at off, high half acks IF
            lanes = (nbytes == 3'd4) ? 3'd2 : nbytes;
            if (nbytes == 3'd4) begin
              ack = item.write_data[31:16];
            end
          end else if (off < iwhc_pkg::BYTE_WC_LO) begin
            lanes = 3'd0;
            if (nbytes == 3'd1) begin
              ack = (off == iwhc_pkg::BYTE_IF_LO) ? {8'h00, item.write_data[7:0]}
                                                  : {item.write_data[7:0], 8'h00};
            end else begin
              ack = item.write_data[15:0];
            end
          end else begin
            lanes = nbytes;
          end
          for (int k = 0; k < 4; k++) begin
            if (3'(k) < lanes) begin
              idx       = off + 4'(k);
              lane_byte = item.write_data[8*k +: 8];
              case (idx)
                iwhc_pkg::BYTE_IE_LO:  irq_enable_next[7:0]     = lane_byte;
                iwhc_pkg::BYTE_IE_HI:  irq_enable_next[15:8]    = lane_byte;
                iwhc_pkg::BYTE_IF_LO:  irq_flags_next[7:0]      = lane_byte;
                iwhc_pkg::BYTE_IF_HI:  irq_flags_next[15:8]     = lane_byte;
                iwhc_pkg::BYTE_WC_LO:  wait_control_next[7:0]   = lane_byte;
                iwhc_pkg::BYTE_WC_HI:  wait_control_next[14:8]  = lane_byte[6:0];
                iwhc_pkg::BYTE_IME_LO: master_enable_next[7:0]  = lane_byte;
                iwhc_pkg::BYTE_IME_HI: master_enable_next[15:8] = lane_byte;
                default: ;
              endcase
            end
          end
          irq_flags_next = irq_flags_next & ~ack;
        end else if (item.io_offset == iwhc_pkg::SYS_BASE ||
                     item.io_offset == iwhc_pkg::SYS_HALT) begin
          lanes = (nbytes == 3'd1) ? 3'd1 : 3'd2;
          for (int k = 0; k < 2; k++) begin
            if (3'(k) < lanes) begin
              lane_byte = item.write_data[8*k +: 8];
              case (2'(item.io_offset[0]) + 2'(k))
                2'd0:    post_boot_flag_next = lane_byte;
                2'd1:    halt_bit = lane_byte[7];
                default: ;
              endcase
            end
          end
          // halt control byte is only ever consumed by this check
          if (nbytes != 3'd1 || item.io_offset[0]) begin
            halt_state_next = !halt_bit;
          end
        end
      end

      iwhc_pkg::CMD_RAISE: begin
        irq_flags_next = irq_flags | ({2'b00, item.irq_sources} & iwhc_pkg::IRQ_SRC_MASK);
        do_check       = 1'b1;
      end

      iwhc_pkg::CMD_QUERY: begin
        result.wait_cycles = wait_cycles;
      end

      default: ;
    endcase

    if (do_check) begin
      if ((irq_enable_next & irq_flags_next) != 16'h0000) begin
        irq_line_next   = master_enable_next[0];
        halt_state_next = 1'b0;
      end else begin
        irq_line_next = 1'b0;
      end
    end

    result.irq_pending = irq_line_next;
    result.halted      = halt_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable     <= '0;
      irq_flags      <= '0;
      wait_control   <= '0;
      master_enable  <= '0;
      post_boot_flag <= '0;
      halt_state     <= 1'b0;
      irq_line       <= 1'b0;
    end else if (fire) begin
      irq_enable     <= irq_enable_next;
      irq_flags      <= irq_flags_next;
      wait_control   <= wait_control_next;
      master_enable  <= master_enable_next;
      post_boot_flag <= post_boot_flag_next;
      halt_state     <= halt_state_next;
      irq_line       <= irq_line_next;
    end
  end

  // line high only while an enabled flag is pending and IME allows it
  a_line_needs_pending: assert property (@(posedge clk) disable iff (rst)
    irq_line |-> (((irq_enable & irq_flags) != 16'h0000) && master_enable[0]))
    else $error("irq line high without an enabled pending interrupt");

endmodule

`default_nettype wire
